// File: rtl/core/mqttpd_pkg.sv
package mqttpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_IDENT   = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  localparam logic [2:0] CLS_HEADER    = 3'd0;
  localparam logic [2:0] CLS_LENGTH    = 3'd1;
  localparam logic [2:0] CLS_TOPIC_LEN = 3'd2;
  localparam logic [2:0] CLS_TOPIC     = 3'd3;
  localparam logic [2:0] CLS_IDENT     = 3'd4;
  localparam logic [2:0] CLS_PAYLOAD   = 3'd5;
  localparam logic [2:0] CLS_DISCARD   = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_PUB   = 3'd1;
  localparam logic [2:0] ERR_LONG_LEN  = 3'd2;
  localparam logic [2:0] ERR_TOPIC_OVR = 3'd3;
  localparam logic [2:0] ERR_IDENT_OVR = 3'd4;

  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam int unsigned LEN_W = 28;

  // One decoded byte with the packet fields as they stand after it.
  typedef struct packed {
    logic [2:0]       byte_class;
    logic [7:0]       byte_out;
    logic             dup_flag;
    logic [1:0]       qos_level;
    logic             retain_flag;
    logic [15:0]      packet_ident;
    logic [15:0]      topic_length;
    logic [LEN_W-1:0] payload_length;
    logic [2:0]       error_code;
    logic             packet_end;
  } result_t;

endpackage

// File: rtl/core/mqtt_publish_decoder.sv
// Each byte's result passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full (in_stall_o low).
// A two-entry queue between parser and output register absorbs output stalls.
// Reset (rst_ni low, asynchronous) puts the parser in the header phase with all
// fields at zero and empties the queue and the output register.
module mqtt_publish_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_class_o,
  output logic [7:0]  byte_out_o,
  output logic        dup_flag_o,
  output logic [1:0]  qos_level_o,
  output logic        retain_flag_o,
  output logic [15:0] packet_ident_o,
  output logic [15:0] topic_length_o,
  output logic [27:0] payload_length_o,
  output logic [2:0]  error_code_o,
  output logic        packet_end_o
);

  mqttpd_pkg::result_t front_res, queue_res, out_res;
  logic accept, full, empty, pop;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mqttpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .result_o       (front_res)
  );

  mqttpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_res),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (queue_res)
  );

  mqttpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .data_i      (queue_res),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign byte_class_o     = out_res.byte_class;
  assign byte_out_o       = out_res.byte_out;
  assign dup_flag_o       = out_res.dup_flag;
  assign qos_level_o      = out_res.qos_level;
  assign retain_flag_o    = out_res.retain_flag;
  assign packet_ident_o   = out_res.packet_ident;
  assign topic_length_o   = out_res.topic_length;
  assign payload_length_o = out_res.payload_length;
  assign error_code_o     = out_res.error_code;
  assign packet_end_o     = out_res.packet_end;

endmodule

// File: rtl/core/mqttpd_front.sv
module mqttpd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    packet_start_i,
  output mqttpd_pkg::result_t     result_o
);

  mqttpd_pkg::phase_e phase_q, phase_d, e_phase;
  logic [mqttpd_pkg::LEN_W-1:0] bytes_left_q, bytes_left_d, e_bytes_left;
  logic [mqttpd_pkg::LEN_W-1:0] pay_count_q, pay_count_d, e_pay_count;
  logic [mqttpd_pkg::LEN_W-1:0] len_addend, bytes_dec;
  logic [1:0]  lbc_q, lbc_d, e_lbc;
  logic [3:0]  flags_q, flags_d, e_flags;
  logic [15:0] topic_len_q, topic_len_d, e_topic_len;
  logic [15:0] topic_left_q, topic_left_d, e_topic_left;
  logic [15:0] ident_q, ident_d, e_ident;
  logic [2:0]  error_q, error_d, e_error;
  logic [2:0]  byte_class;
  logic        pkt_end, topic_done, payload_go;

  // A start byte sees the cleared state and is parsed as a header.
  always_comb begin
    if (packet_start_i) begin
      e_phase       = mqttpd_pkg::PH_HEADER;
      e_bytes_left  = '0;
      e_pay_count   = '0;
      e_lbc         = '0;
      e_flags       = '0;
      e_topic_len   = '0;
      e_topic_left  = '0;
      e_ident       = '0;
      e_error       = mqttpd_pkg::ERR_NONE;
    end else begin
      e_phase       = phase_q;
      e_bytes_left  = bytes_left_q;
      e_pay_count   = pay_count_q;
      e_lbc         = lbc_q;
      e_flags       = flags_q;
      e_topic_len   = topic_len_q;
      e_topic_left  = topic_left_q;
      e_ident       = ident_q;
      e_error       = error_q;
    end
  end

  always_comb begin
    case (e_lbc)
      2'd0:    len_addend = {21'd0, data_byte_i[6:0]};
      2'd1:    len_addend = {14'd0, data_byte_i[6:0], 7'd0};
      2'd2:    len_addend = {7'd0, data_byte_i[6:0], 14'd0};
      2'd3:    len_addend = {data_byte_i[6:0], 21'd0};
      default: len_addend = '0;
    endcase
  end

  assign bytes_dec = (e_bytes_left != '0) ? e_bytes_left - 28'd1 : e_bytes_left;

  // Next state.
  always_comb begin
    phase_d       = e_phase;
    bytes_left_d  = e_bytes_left;
    pay_count_d   = e_pay_count;
    lbc_d         = e_lbc;
    flags_d       = e_flags;
    topic_len_d   = e_topic_len;
    topic_left_d  = e_topic_left;
    ident_d       = e_ident;
    error_d       = e_error;
    pkt_end       = 1'b0;
    topic_done    = 1'b0;
    payload_go    = 1'b0;

    case (e_phase)
      mqttpd_pkg::PH_HEADER: begin
        if (data_byte_i[7:4] != mqttpd_pkg::TYPE_PUBLISH) begin
          error_d = mqttpd_pkg::ERR_NOT_PUB;
          phase_d = mqttpd_pkg::PH_DONE;
          pkt_end = 1'b1;
        end else begin
          flags_d      = data_byte_i[3:0];
          bytes_left_d = '0;
          lbc_d        = '0;
          phase_d      = mqttpd_pkg::PH_LENGTH;
        end
      end
      mqttpd_pkg::PH_LENGTH: begin
        bytes_left_d = e_bytes_left + len_addend;
        if (data_byte_i[7]) begin
          if (e_lbc == 2'd3) begin
            error_d = mqttpd_pkg::ERR_LONG_LEN;
            phase_d = mqttpd_pkg::PH_DONE;
            pkt_end = 1'b1;
          end else begin
            lbc_d = e_lbc + 2'd1;
          end
        end else if (bytes_left_d < 28'd2) begin
          error_d = mqttpd_pkg::ERR_TOPIC_OVR;
          phase_d = mqttpd_pkg::PH_DONE;
          pkt_end = 1'b1;
        end else begin
          phase_d = mqttpd_pkg::PH_TLEN_HI;
        end
      end
      mqttpd_pkg::PH_TLEN_HI: begin
        topic_len_d  = {data_byte_i, 8'd0};
        bytes_left_d = bytes_dec;
        phase_d      = mqttpd_pkg::PH_TLEN_LO;
      end
      mqttpd_pkg::PH_TLEN_LO: begin
        topic_len_d  = e_topic_len | {8'd0, data_byte_i};
        bytes_left_d = bytes_dec;
        if ({12'd0, topic_len_d} > bytes_left_d) begin
          error_d = mqttpd_pkg::ERR_TOPIC_OVR;
          phase_d = mqttpd_pkg::PH_DONE;
          pkt_end = 1'b1;
        end else begin
          topic_left_d = topic_len_d;
          if (topic_len_d == 16'd0) begin
            topic_done = 1'b1;
          end else begin
            phase_d = mqttpd_pkg::PH_TOPIC;
          end
        end
      end
      mqttpd_pkg::PH_TOPIC: begin
        bytes_left_d = bytes_dec;
        if (e_topic_left != 16'd0) begin
          topic_left_d = e_topic_left - 16'd1;
        end
        if (topic_left_d == 16'd0) begin
          topic_done = 1'b1;
        end
      end
      mqttpd_pkg::PH_IDENT: begin
        bytes_left_d = bytes_dec;
        if (e_lbc == 2'd0) begin
          ident_d = {data_byte_i, 8'd0};
          lbc_d   = 2'd1;
        end else begin
          ident_d    = e_ident | {8'd0, data_byte_i};
          payload_go = 1'b1;
        end
      end
      mqttpd_pkg::PH_PAYLOAD: begin
        bytes_left_d = bytes_dec;
        if (bytes_left_d == '0) begin
          phase_d = mqttpd_pkg::PH_DONE;
          pkt_end = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // With the topic read, a packet id follows when qos is nonzero.
    if (topic_done) begin
      if (e_flags[2:1] != 2'd0) begin
        if (bytes_left_d < 28'd2) begin
          error_d = mqttpd_pkg::ERR_IDENT_OVR;
          phase_d = mqttpd_pkg::PH_DONE;
          pkt_end = 1'b1;
        end else begin
          lbc_d   = '0;
          phase_d = mqttpd_pkg::PH_IDENT;
        end
      end else begin
        payload_go = 1'b1;
      end
    end

    if (payload_go) begin
      pay_count_d = bytes_left_d;
      if (bytes_left_d == '0) begin
        phase_d = mqttpd_pkg::PH_DONE;
        pkt_end = 1'b1;
      end else begin
        phase_d = mqttpd_pkg::PH_PAYLOAD;
      end
    end
  end

  // Outputs: the class follows from the phase the byte arrives in.
  always_comb begin
    case (e_phase)
      mqttpd_pkg::PH_HEADER:  byte_class = mqttpd_pkg::CLS_HEADER;
      mqttpd_pkg::PH_LENGTH:  byte_class = mqttpd_pkg::CLS_LENGTH;
      mqttpd_pkg::PH_TLEN_HI: byte_class = mqttpd_pkg::CLS_TOPIC_LEN;
      mqttpd_pkg::PH_TLEN_LO: byte_class = mqttpd_pkg::CLS_TOPIC_LEN;
      mqttpd_pkg::PH_TOPIC:   byte_class = mqttpd_pkg::CLS_TOPIC;
      mqttpd_pkg::PH_IDENT:   byte_class = mqttpd_pkg::CLS_IDENT;
      mqttpd_pkg::PH_PAYLOAD: byte_class = mqttpd_pkg::CLS_PAYLOAD;
      default:                byte_class = mqttpd_pkg::CLS_DISCARD;
    endcase
  end

  always_comb begin
    result_o.byte_class     = byte_class;
    result_o.byte_out       = data_byte_i;
    result_o.dup_flag       = flags_d[3];
    result_o.qos_level      = flags_d[2:1];
    result_o.retain_flag    = flags_d[0];
    result_o.packet_ident   = ident_d;
    result_o.topic_length   = topic_len_d;
    result_o.payload_length = pay_count_d;
    result_o.error_code     = error_d;
    result_o.packet_end     = pkt_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= mqttpd_pkg::PH_HEADER;
      bytes_left_q  <= '0;
      pay_count_q   <= '0;
      lbc_q         <= '0;
      flags_q       <= '0;
      topic_len_q   <= '0;
      topic_left_q  <= '0;
      ident_q       <= '0;
      error_q       <= mqttpd_pkg::ERR_NONE;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      pay_count_q   <= pay_count_d;
      lbc_q         <= lbc_d;
      flags_q       <= flags_d;
      topic_len_q   <= topic_len_d;
      topic_left_q  <= topic_left_d;
      ident_q       <= ident_d;
      error_q       <= error_d;
    end
  end

endmodule

// File: rtl/core/mqttpd_queue.sv
module mqttpd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mqttpd_pkg::result_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output mqttpd_pkg::result_t pop_data_o
);

  mqttpd_pkg::result_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/core/mqttpd_back.sv
module mqttpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  mqttpd_pkg::result_t data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mqttpd_pkg::result_t result_o
);

  logic                valid_q;
  mqttpd_pkg::result_t result_q;

  // Load the output register whenever it is empty or being taken.
  assign pop_o       = !empty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// File: rtl/core/mqttpd_checker.sv
module mqttpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  byte_class_o,
  input logic [7:0]  byte_out_o,
  input logic [1:0]  qos_level_o,
  input logic [2:0]  error_code_o,
  input logic        packet_end_o
);

  // A stalled transaction stays offered with the same byte and class.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(byte_out_o) && $stable(byte_class_o))
    else $error("output transaction changed while stalled");

  // Bytes after the end of a packet never carry the end mark.
  a_discard_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_class_o == mqttpd_pkg::CLS_DISCARD |-> !packet_end_o)
    else $error("discarded byte marked as packet end");

  // A packet id is only parsed when the header asked for one.
  a_ident_qos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_class_o == mqttpd_pkg::CLS_IDENT |-> qos_level_o != 2'd0)
    else $error("packet id byte with qos zero");

  // A wrong packet type ends on the header byte itself.
  a_not_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == mqttpd_pkg::ERR_NOT_PUB |->
      (byte_class_o == mqttpd_pkg::CLS_HEADER && packet_end_o) ||
      byte_class_o == mqttpd_pkg::CLS_DISCARD)
    else $error("type error reported off the header byte");

endmodule

bind mqtt_publish_decoder mqttpd_checker u_mqttpd_checker (.*);
